// File: src/hhlp_pkg.sv
`default_nettype none
package hhlp_pkg;

  // Default capture capacities; one slot of each is never filled.
  localparam int PATH_CAP_DEF = 128;
  localparam int ARGS_CAP_DEF = 128;
  localparam int AUTH_CAP_DEF = 64;

  // Result kinds
  localparam logic [1:0] KIND_PATH = 2'd0;
  localparam logic [1:0] KIND_ARGS = 2'd1;
  localparam logic [1:0] KIND_AUTH = 2'd2;
  localparam logic [1:0] KIND_SUM  = 2'd3;

  // Method codes
  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_POST = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ARGS_EN = 1'b0;
  localparam logic CFG_AUTH_EN = 1'b1;

  // Prefix selectors; the higher one would win if two completed on the same byte
  localparam logic [1:0] PFX_GET  = 2'd0;
  localparam logic [1:0] PFX_POST = 2'd1;
  localparam logic [1:0] PFX_CLEN = 2'd2;
  localparam logic [1:0] PFX_AUTH = 2'd3;

  localparam logic [4:0] PFX_LEN [4] = '{5'd4, 5'd5, 5'd16, 5'd21};

  localparam logic [8*4-1:0]  GET_STR  = "GET ";
  localparam logic [8*5-1:0]  POST_STR = "POST ";
  localparam logic [8*16-1:0] CLEN_STR = "Content-Length: ";
  localparam logic [8*21-1:0] AUTH_STR = "Authorization: Basic ";

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  chr;
    logic [6:0]  index;
    logic [1:0]  method;
    logic [31:0] content_len;
    logic [6:0]  path_len;
    logic [6:0]  args_len;
    logic [5:0]  auth_len;
    logic        auth_basic;
    logic        last;
  } res_t;

  // Results of one accepted byte: count 0 to 2, first in a, second in b.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       a;
    res_t       b;
  } push_t;

  // Character of a prefix at a position; zero beyond its end.
  function automatic logic [7:0] pfx_char(input logic [1:0] sel, input logic [4:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (sel)
      PFX_GET:  if (pos < PFX_LEN[0]) c = GET_STR[8*(3 - int'(pos)) +: 8];
      PFX_POST: if (pos < PFX_LEN[1]) c = POST_STR[8*(4 - int'(pos)) +: 8];
      PFX_CLEN: if (pos < PFX_LEN[2]) c = CLEN_STR[8*(15 - int'(pos)) +: 8];
      PFX_AUTH: if (pos < PFX_LEN[3]) c = AUTH_STR[8*(20 - int'(pos)) +: 8];
      default:  c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/hhlp_parser.sv
`default_nettype none
module hhlp_parser
  import hhlp_pkg::*;
#(
  parameter int PATH_CAP = PATH_CAP_DEF,
  parameter int ARGS_CAP = ARGS_CAP_DEF,
  parameter int AUTH_CAP = AUTH_CAP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       acc,
  input  wire logic       req_type,
  input  wire logic [7:0] ch,
  input  wire logic       line_end,
  output push_t           push
);

  localparam int PW = (PATH_CAP > 1) ? $clog2(PATH_CAP) : 1;
  localparam int AW = (ARGS_CAP > 1) ? $clog2(ARGS_CAP) : 1;
  localparam int UW = (AUTH_CAP > 1) ? $clog2(AUTH_CAP) : 1;
  localparam logic [PW:0] PCAP = (PW+1)'(PATH_CAP);
  localparam logic [AW:0] ACAP = (AW+1)'(ARGS_CAP);
  localparam logic [UW:0] UCAP = (UW+1)'(AUTH_CAP);

  typedef enum logic [2:0] {
    PH_PREFIX, PH_PATH, PH_ARGS, PH_CLEN, PH_AUTH, PH_SKIP
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [4:0]   pos_r, pos_nxt;
  logic [3:0]   alive_r, alive_nxt;
  logic [1:0]   method_r, method_nxt;
  logic [31:0]  len_r, len_nxt;
  logic [PW-1:0] pcnt_r, pcnt_nxt;
  logic [AW-1:0] acnt_r, acnt_nxt;
  logic [UW-1:0] ucnt_r, ucnt_nxt;
  logic         seen_r, seen_nxt;
  logic         args_en_r, auth_en_r;

  logic         chr_v, sum_v;
  logic [1:0]   chr_kind;
  logic [6:0]   chr_idx;
  logic [3:0]   alive_v;
  logic         done_v;
  logic [1:0]   done_sel;

  // Zero-extended views so that any capacity maps onto the 7- and 6-bit fields
  logic [PW+6:0] pcnt_old_x, pcnt_new_x;
  logic [AW+6:0] acnt_old_x, acnt_new_x;
  logic [UW+6:0] ucnt_old_x, ucnt_new_x;
  res_t          stat;

  assign pcnt_old_x = {7'd0, pcnt_r};
  assign acnt_old_x = {7'd0, acnt_r};
  assign ucnt_old_x = {7'd0, ucnt_r};
  assign pcnt_new_x = {7'd0, pcnt_nxt};
  assign acnt_new_x = {7'd0, acnt_nxt};
  assign ucnt_new_x = {7'd0, ucnt_nxt};

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    alive_nxt  = alive_r;
    method_nxt = method_r;
    len_nxt    = len_r;
    pcnt_nxt   = pcnt_r;
    acnt_nxt   = acnt_r;
    ucnt_nxt   = ucnt_r;
    seen_nxt   = seen_r;
    chr_v      = 1'b0;
    sum_v      = 1'b0;
    chr_kind   = KIND_PATH;
    chr_idx    = 7'd0;
    alive_v    = alive_r;
    done_v     = 1'b0;
    done_sel   = PFX_GET;
    if (acc && req_type) begin
      phase_nxt  = PH_PREFIX;
      pos_nxt    = 5'd0;
      alive_nxt  = 4'hF;
      method_nxt = METH_NONE;
      len_nxt    = 32'd0;
      pcnt_nxt   = '0;
      acnt_nxt   = '0;
      ucnt_nxt   = '0;
      seen_nxt   = 1'b0;
    end else if (acc) begin
      case (phase_r)
        PH_PREFIX: begin
          for (int i = 0; i < 4; i++) begin
            if (alive_r[i]) begin
              if (pos_r < PFX_LEN[i] && pfx_char(2'(i), pos_r) == ch) begin
                if (pos_r + 5'd1 == PFX_LEN[i]) begin
                  done_v   = 1'b1;
                  done_sel = 2'(i);
                end
              end else begin
                alive_v[i] = 1'b0;
              end
            end
          end
          alive_nxt = alive_v;
          if (pos_r != 5'd31) pos_nxt = pos_r + 5'd1;
          if (alive_v == 4'd0) begin
            phase_nxt = PH_SKIP;
          end else if (done_v) begin
            case (done_sel)
              PFX_GET, PFX_POST: begin
                method_nxt = (done_sel == PFX_GET) ? METH_GET : METH_POST;
                pcnt_nxt   = '0;
                phase_nxt  = PH_PATH;
              end
              PFX_CLEN: begin
                len_nxt   = 32'd0;
                phase_nxt = PH_CLEN;
              end
              default: begin
                if (auth_en_r) begin
                  seen_nxt  = 1'b1;
                  ucnt_nxt  = '0;
                  phase_nxt = PH_AUTH;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_PATH: begin
          if (ch == CH_NUL || ch == CH_SPACE) begin
            phase_nxt = PH_SKIP;
          end else if (ch == CH_QUEST) begin
            if (args_en_r) begin
              acnt_nxt  = '0;
              phase_nxt = PH_ARGS;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else if ({1'b0, pcnt_r} + 1'b1 < PCAP) begin
            chr_v    = 1'b1;
            chr_kind = KIND_PATH;
            chr_idx  = pcnt_old_x[6:0];
            pcnt_nxt = pcnt_r + 1'b1;
          end
        end
        PH_ARGS: begin
          if (ch == CH_NUL || ch == CH_SPACE) begin
            phase_nxt = PH_SKIP;
          end else if ({1'b0, acnt_r} + 1'b1 < ACAP) begin
            chr_v    = 1'b1;
            chr_kind = KIND_ARGS;
            chr_idx  = acnt_old_x[6:0];
            acnt_nxt = acnt_r + 1'b1;
          end
        end
        PH_CLEN: begin
          // Times ten as two shifts and an add; wraps modulo 2^32.
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            len_nxt = (len_r << 3) + (len_r << 1) + {28'd0, 4'(ch - CH_ZERO)};
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_AUTH: begin
          if (ch == CH_NUL || ch == CH_SPACE) begin
            phase_nxt = PH_SKIP;
          end else if ({1'b0, ucnt_r} + 1'b1 < UCAP) begin
            chr_v    = 1'b1;
            chr_kind = KIND_AUTH;
            chr_idx  = ucnt_old_x[6:0];
            ucnt_nxt = ucnt_r + 1'b1;
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase
      if (line_end) begin
        sum_v     = 1'b1;
        pos_nxt   = 5'd0;
        alive_nxt = 4'hF;
        phase_nxt = PH_PREFIX;
      end
    end
  end

  // Status fields always show the state after this byte.
  always_comb begin
    stat             = '0;
    stat.method      = method_nxt;
    stat.content_len = len_nxt;
    stat.path_len    = pcnt_new_x[6:0];
    stat.args_len    = acnt_new_x[6:0];
    stat.auth_len    = ucnt_new_x[5:0];
    stat.auth_basic  = seen_nxt;
  end

  always_comb begin
    push        = '0;
    push.a      = stat;
    push.b      = stat;
    push.b.kind = KIND_SUM;
    push.b.last = 1'b1;
    if (chr_v) begin
      push.a.kind  = chr_kind;
      push.a.chr   = ch;
      push.a.index = chr_idx;
      push.cnt     = sum_v ? 2'd2 : 2'd1;
    end else if (sum_v) begin
      push.a.kind = KIND_SUM;
      push.a.last = 1'b1;
      push.cnt    = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PREFIX;
      pos_r     <= 5'd0;
      alive_r   <= 4'hF;
      method_r  <= METH_NONE;
      len_r     <= 32'd0;
      pcnt_r    <= '0;
      acnt_r    <= '0;
      ucnt_r    <= '0;
      seen_r    <= 1'b0;
      args_en_r <= 1'b1;
      auth_en_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      alive_r  <= alive_nxt;
      method_r <= method_nxt;
      len_r    <= len_nxt;
      pcnt_r   <= pcnt_nxt;
      acnt_r   <= acnt_nxt;
      ucnt_r   <= ucnt_nxt;
      seen_r   <= seen_nxt;
      if (cfg_we && cfg_index == CFG_ARGS_EN) args_en_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_AUTH_EN) auth_en_r <= cfg_data;
    end
  end

`ifndef SYNTH
  // Path and argument capture only follow a completed GET or POST prefix.
  a_capture_needs_method: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PATH || phase_r == PH_ARGS) |-> method_r != METH_NONE)
    else $error("path or argument capture without a method");
  // Two results are always a character followed by the line summary.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> (push.a.kind != KIND_SUM && !push.a.last && push.b.last))
    else $error("bad ordering of a result pair");
  // A line end always leaves the block matching prefixes again.
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !req_type && line_end) |=> (phase_r == PH_PREFIX && pos_r == 5'd0))
    else $error("prefix matching not restarted after line end");
`endif

endmodule
`default_nettype wire

// File: src/hhlp_out_queue.sv
`default_nettype none
module hhlp_out_queue
  import hhlp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space_ok,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  res_t       mem [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // Room for two more results, so one byte can always be taken.
  assign space_ok  = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = wr_r + push.cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_r] <= push.a;
    if (push.cnt == 2'd2) mem[wr_r + 2'd1] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");
  a_fill_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[1:0] == wr_r - rd_r))
    else $error("fill count disagrees with pointers");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("fill count not decremented on pop");
`endif

endmodule
`default_nettype wire

// File: src/http_header_line_parser.sv
`default_nettype none
// HTTP header line parser. One header byte is accepted per clock while the
// four-entry result queue holds two results or fewer; a byte yields up to two
// results (a captured character and, on the line's last byte, a summary), and
// each result is written into the queue before it can leave. The output
// side moves one result per clock while out_tready is high, so bytes carrying
// both a character and a summary fill the queue faster than it drains; with
// results draining at full speed the queue absorbs the first such bytes, and
// once it holds three results the input is held back while it drains. A
// new-request item (tuser set) clears all parse state and gives no result.
// Configuration writes are always taken at once.
module http_header_line_parser
  import hhlp_pkg::*;
#(
  parameter int PATH_CAP = PATH_CAP_DEF,
  parameter int ARGS_CAP = ARGS_CAP_DEF,
  parameter int AUTH_CAP = AUTH_CAP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // ch
  input  wire logic        in_tuser,  // req_type
  input  wire logic        in_tlast,  // line_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_char, out_index, method, content_len, path_len, args_len, auth_len,
  // auth_basic, then zero fill
  output logic [71:0]      out_tdata,
  output logic [1:0]       out_tuser, // out_kind
  output logic             out_tlast  // last
);

  push_t push;
  res_t  res;
  logic  space_ok;
  logic  acc;

  assign cfg_ready = 1'b1;
  assign in_tready = space_ok;
  assign acc       = in_tvalid && space_ok;

  hhlp_parser #(
    .PATH_CAP (PATH_CAP),
    .ARGS_CAP (ARGS_CAP),
    .AUTH_CAP (AUTH_CAP)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .req_type  (in_tuser),
    .ch        (in_tdata),
    .line_end  (in_tlast),
    .push      (push)
  );

  hhlp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.auth_basic, res.auth_len, res.args_len, res.path_len,
                      res.content_len, res.method, res.index, res.chr};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
`default_nettype wire
